// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file mpsm_checker.sv.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- sv/mpsm_pkg.sv -----
package mpsm_pkg;

	localparam int SLOTS   = 8;
	localparam int MAX_LEN = 16;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int POS_W   = $clog2(MAX_LEN);
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	localparam int ID_W    = 16;
	localparam int OP_W    = 2;

	localparam logic [7:0]       DIGIT_LO = 8'h30;  // '0'
	localparam logic [7:0]       DIGIT_HI = 8'h39;  // '9'
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_LEN);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_ELEM = 2'd0,
		OP_LOAD_SLOT = 2'd1,
		OP_SCAN      = 2'd2,
		OP_NOP       = 2'd3
	} op_t;

	// Command broadcast to every cell for one accepted transaction.
	typedef struct packed {
		logic              load_elem;
		logic              load_slot;
		logic              scan;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  position;
		logic              elem_digit;
		logic [7:0]        elem_byte;
		logic [LEN_W-1:0]  length;
		logic [ID_W-1:0]   id;
		logic [7:0]        scan_byte;
	} cell_cmd_t;

	// Priority result that ripples from slot 0 upward.
	typedef struct packed {
		logic              found;
		logic [ID_W-1:0]   id;
		logic [SLOT_W-1:0] slot;
	} chain_t;

endpackage

// ----- sv/mpsm_cell.sv -----
module mpsm_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [mpsm_pkg::SLOT_W-1:0] cell_idx,
	input  mpsm_pkg::cell_cmd_t       cmd,
	input  logic                      clear_all,
	input  mpsm_pkg::chain_t          chain_in,
	output mpsm_pkg::chain_t          chain_out
);
	import mpsm_pkg::*;

	logic [8:0]       elem_q [MAX_LEN];
	logic [LEN_W-1:0] len_q;
	logic [ID_W-1:0]  id_q;
	logic [POS_W-1:0] prog_q;

	logic             sel;
	logic [POS_W-1:0] pr_eff;
	logic [8:0]       elem;
	logic             hit_elem;
	logic [LEN_W-1:0] pr_inc;
	logic             done;
	logic [POS_W-1:0] prog_next;

	assign sel = (cmd.slot == cell_idx);

	// progress at or past the length restarts at element 0
	assign pr_eff = ({1'b0, prog_q} >= len_q) ? '0 : prog_q;
	assign elem   = elem_q[pr_eff];
	assign hit_elem = elem[8] ? (cmd.scan_byte >= DIGIT_LO && cmd.scan_byte <= DIGIT_HI)
	                          : (elem[7:0] == cmd.scan_byte);
	assign pr_inc = {1'b0, pr_eff} + LEN_W'(1);
	assign done   = cmd.scan && (len_q != '0) && hit_elem && (pr_inc >= len_q);

	always_comb begin
		prog_next = prog_q;
		if (len_q != '0) begin
			if (!hit_elem || done) begin
				prog_next = '0;
			end else begin
				prog_next = pr_inc[POS_W-1:0];
			end
		end
	end

	always_comb begin
		chain_out = chain_in;
		if (!chain_in.found && done) begin
			chain_out.found = 1'b1;
			chain_out.id    = id_q;
			chain_out.slot  = cell_idx;
		end
	end

	// element store, undefined until written
	always_ff @(posedge clk) begin
		if (cmd.load_elem && sel) begin
			elem_q[cmd.position] <= {cmd.elem_digit, cmd.elem_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			id_q   <= '0;
			prog_q <= '0;
		end else if (cmd.load_slot && sel) begin
			len_q  <= (cmd.length > LEN_MAX) ? LEN_MAX : cmd.length;
			id_q   <= cmd.id;
			prog_q <= '0;
		end else if (cmd.scan) begin
			prog_q <= clear_all ? '0 : prog_next;
		end
	end

endmodule

// ----- sv/multi_pattern_stream_matcher_top.sv -----
// Channel | Handshake          | Payload
// --------+--------------------+----------------------------------------------------
// in      | in_valid/in_stall  | operation slot position element_byte
//         |                    | element_is_digit pattern_length pattern_id byte_in
// out     | out_valid/out_stall| matched match_id match_slot
//
// One transaction per clock while in_stall is low: each accepted item is finished in
// the cycle it is accepted and its result is registered, so it appears in the next cycle.
// The rate is set by the single output register: a new item is taken whenever the
// result register is empty or being drained in the same cycle.
// Reset clears slot lengths, ids and progress; pattern elements are not cleared.
// While out_stall holds a waiting result, in_stall is raised.
module multi_pattern_stream_matcher_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mpsm_pkg::OP_W-1:0]     operation,
	input  logic [mpsm_pkg::SLOT_W-1:0]   slot,
	input  logic [mpsm_pkg::POS_W-1:0]    position,
	input  logic [7:0]                    element_byte,
	input  logic                          element_is_digit,
	input  logic [mpsm_pkg::LEN_W-1:0]    pattern_length,
	input  logic [mpsm_pkg::ID_W-1:0]     pattern_id,
	input  logic [7:0]                    byte_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          matched,
	output logic [mpsm_pkg::ID_W-1:0]     match_id,
	output logic [mpsm_pkg::SLOT_W-1:0]   match_slot
);
	import mpsm_pkg::*;

	logic      accept;
	op_t       op;
	cell_cmd_t cmd;
	chain_t    chain [SLOTS+1];

	// result register
	logic              out_valid_q;
	logic              matched_q;
	logic [ID_W-1:0]   match_id_q;
	logic [SLOT_W-1:0] match_slot_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign op       = op_t'(operation);

	// broadcast command; strobes only live on an accepted transaction
	always_comb begin
		cmd            = '0;
		cmd.load_elem  = accept && (op == OP_LOAD_ELEM);
		cmd.load_slot  = accept && (op == OP_LOAD_SLOT);
		cmd.scan       = accept && (op == OP_SCAN);
		cmd.slot       = slot;
		cmd.position   = position;
		cmd.elem_digit = element_is_digit;
		cmd.elem_byte  = element_byte;
		cmd.length     = pattern_length;
		cmd.id         = pattern_id;
		cmd.scan_byte  = byte_in;
	end

	// chain head: nothing found yet, zero id and slot
	assign chain[0] = '0;

	// one cell per slot; lowest completing slot wins as the result ripples up,
	// and any completion clears every slot's progress
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		mpsm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (SLOT_W'(i)),
			.cmd       (cmd),
			.clear_all (chain[SLOTS].found),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			matched_q    <= 1'b0;
			match_id_q   <= '0;
			match_slot_q <= '0;
		end else if (accept) begin
			out_valid_q  <= 1'b1;
			matched_q    <= chain[SLOTS].found;
			match_id_q   <= chain[SLOTS].id;
			match_slot_q <= chain[SLOTS].slot;
		end else if (!out_stall) begin
			out_valid_q  <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign matched    = matched_q;
	assign match_id   = match_id_q;
	assign match_slot = match_slot_q;

endmodule

// ----- sv/mpsm_checker.sv -----
`include "assert_macros.svh"

module mpsm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [mpsm_pkg::OP_W-1:0]   operation,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        matched,
	input logic [mpsm_pkg::ID_W-1:0]   match_id,
	input logic [mpsm_pkg::SLOT_W-1:0] match_slot
);
	import mpsm_pkg::*;

	// a miss reports zero id and slot
	`ASSERT_SAME(a_miss_zero, out_valid && !matched, match_id == '0 && match_slot == '0)

	// loads and unused codes never report a match
	`ASSERT_NEXT(a_load_no_match, in_valid && !in_stall && operation != OP_SCAN, out_valid && !matched)

	// a waiting result blocks the input side
	`ASSERT_SAME(a_stall_back, out_valid && out_stall, in_stall)

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(matched) && $stable(match_id) && $stable(match_slot))

endmodule

bind multi_pattern_stream_matcher_top mpsm_checker u_mpsm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.operation  (operation),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.matched    (matched),
	.match_id   (match_id),
	.match_slot (match_slot)
);

// ----- verif/multi_pattern_stream_matcher_top_tb.sv -----
`timescale 1ns / 1ps

module multi_pattern_stream_matcher_top_tb;
	import mpsm_pkg::*;

	// One input transaction as the sender presents it.
	typedef struct {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  position;
		logic [7:0]        elem_byte;
		logic              elem_digit;
		logic [LEN_W-1:0]  length;
		logic [ID_W-1:0]   id;
		logic [7:0]        scan_byte;
	} matcher_req_t;

	// Scoreboard: keeps its own copy of the pattern table, lengths, ids and
	// per-slot progress, works out the match for every accepted transaction
	// and compares it with what comes out of the block, in order.
	class match_scoreboard;
		logic [8:0]       elem_table [SLOTS][MAX_LEN]; // {digit class, byte}
		int unsigned      len_table [SLOTS];
		logic [ID_W-1:0]  id_table [SLOTS];
		int unsigned      progress [SLOTS];
		chain_t           expected_matches [$];
		int unsigned      error_count, scan_count, load_count, nop_count, hit_count;
		logic [SLOTS-1:0] slot_hit_mask;

		function new();
			foreach (len_table[i]) begin
				len_table[i] = 0;
				id_table[i]  = '0;
				progress[i]  = 0;
			end
			error_count   = 0;
			scan_count    = 0;
			load_count    = 0;
			nop_count     = 0;
			hit_count     = 0;
			slot_hit_mask = '0;
		endfunction

		function void apply_transaction(matcher_req_t r);
			chain_t      res;
			int          s;
			int unsigned pr;
			logic [8:0]  e;
			bit          hit_elem;
			res = '0;
			case (r.op)
				OP_LOAD_ELEM: begin
					elem_table[r.slot][r.position] = {r.elem_digit, r.elem_byte};
					load_count++;
				end
				OP_LOAD_SLOT: begin
					// oversize lengths saturate; reload restarts this slot only
					len_table[r.slot] = (r.length > LEN_MAX) ? MAX_LEN : int'(r.length);
					id_table[r.slot]  = r.id;
					progress[r.slot]  = 0;
					load_count++;
				end
				OP_SCAN: begin
					scan_count++;
					for (s = 0; s < SLOTS && !res.found; s++) begin
						if (len_table[s] == 0)
							continue;
						pr = progress[s];
						if (pr >= len_table[s])
							pr = 0;
						e = elem_table[s][pr];
						if (e[8])
							hit_elem = (r.scan_byte >= DIGIT_LO) && (r.scan_byte <= DIGIT_HI);
						else
							hit_elem = (e[7:0] == r.scan_byte);
						// a miss drops to zero without retrying element 0
						if (hit_elem) begin
							pr++;
							if (pr >= len_table[s]) begin
								res.found = 1'b1;
								res.id    = id_table[s];
								res.slot  = SLOT_W'(s);
								pr        = 0;
							end
							progress[s] = pr;
						end else begin
							progress[s] = 0;
						end
					end
					if (res.found) begin
						foreach (progress[i])
							progress[i] = 0;
						hit_count++;
						slot_hit_mask[res.slot] = 1'b1;
					end
				end
				default: begin
					nop_count++;
				end
			endcase
			expected_matches.push_back(res);
		endfunction

		function void check_match(logic m, logic [ID_W-1:0] id, logic [SLOT_W-1:0] sl);
			chain_t want;
			if (expected_matches.size() == 0) begin
				$error("unexpected result: matched=%0d match_id=%h match_slot=%0d", m, id, sl);
				error_count++;
				return;
			end
			want = expected_matches.pop_front();
			if (m !== want.found) begin
				$error("matched: expected %0d, actual %0d", want.found, m);
				error_count++;
			end
			if (id !== want.id) begin
				$error("match_id: expected %h, actual %h", want.id, id);
				error_count++;
			end
			if (sl !== want.slot) begin
				$error("match_slot: expected %0d, actual %0d", want.slot, sl);
				error_count++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     operation = '0;
	logic [SLOT_W-1:0]   slot = '0;
	logic [POS_W-1:0]    position = '0;
	logic [7:0]          element_byte = '0;
	logic                element_is_digit = 1'b0;
	logic [LEN_W-1:0]    pattern_length = '0;
	logic [ID_W-1:0]     pattern_id = '0;
	logic [7:0]          byte_in = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                matched;
	logic [ID_W-1:0]     match_id;
	logic [SLOT_W-1:0]   match_slot;

	match_scoreboard sb = new();

	// Stimulus-side mirror of the table, so that a slot is only ever enabled
	// over elements that have been written since reset (the element store is
	// not cleared by reset and must never be read before it is written).
	bit          written [SLOTS][MAX_LEN];
	logic [8:0]  gen_elem [SLOTS][MAX_LEN];
	int unsigned gen_len [SLOTS];
	logic [7:0]  scan_plan [$];
	int unsigned stall_cyc = 0;

	multi_pattern_stream_matcher_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.slot             (slot),
		.position         (position),
		.element_byte     (element_byte),
		.element_is_digit (element_is_digit),
		.pattern_length   (pattern_length),
		.pattern_id       (pattern_id),
		.byte_in          (byte_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.matched          (matched),
		.match_id         (match_id),
		.match_slot       (match_slot)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: stall behavior rotates through free flow, light random stall,
	// heavy random stall and a fixed one-in-three stall.
	always @(posedge clk) begin
		stall_cyc <= stall_cyc + 1;
		case ((stall_cyc / 150) % 4)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_cyc % 3 == 0);
		endcase
	end

	// Monitor: everything is sampled at the edge, before any testbench NBA
	// lands, so acceptance is seen exactly as the block sees it.
	always @(posedge clk) begin
		matcher_req_t seen;
		if (arst_n) begin
			if (in_valid && in_stall === 1'b0) begin
				seen.op         = op_t'(operation);
				seen.slot       = slot;
				seen.position   = position;
				seen.elem_byte  = element_byte;
				seen.elem_digit = element_is_digit;
				seen.length     = pattern_length;
				seen.id         = pattern_id;
				seen.scan_byte  = byte_in;
				sb.apply_transaction(seen);
			end
			if (out_valid === 1'b1 && !out_stall)
				sb.check_match(matched, match_id, match_slot);
		end
	end

	// Bytes that make matches likely: the letters a and b, '[' (never a digit),
	// digits and both byte extremes, plus the occasional fully random byte.
	function automatic logic [7:0] pick_pattern_byte();
		case ($urandom_range(0, 7))
			0: return "a";
			1: return "b";
			2: return "[";
			3, 4: return DIGIT_LO + 8'($urandom_range(0, 9));
			5: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Every field random, so unused fields toggle too.
	function automatic matcher_req_t any_req();
		matcher_req_t r;
		r.op         = op_t'($urandom_range(0, 3));
		r.slot       = SLOT_W'($urandom_range(0, SLOTS - 1));
		r.position   = POS_W'($urandom_range(0, MAX_LEN - 1));
		r.elem_byte  = 8'($urandom_range(0, 255));
		r.elem_digit = 1'($urandom_range(0, 1));
		r.length     = LEN_W'($urandom_range(0, 31));
		r.id         = ID_W'($urandom_range(0, 65535));
		r.scan_byte  = 8'($urandom_range(0, 255));
		return r;
	endfunction

	function automatic matcher_req_t elem_req(int s, int p, logic [7:0] b, bit dig);
		matcher_req_t r;
		r            = any_req();
		r.op         = OP_LOAD_ELEM;
		r.slot       = SLOT_W'(s);
		r.position   = POS_W'(p);
		r.elem_byte  = b;
		r.elem_digit = dig;
		return r;
	endfunction

	function automatic matcher_req_t slot_req(int s, int len, logic [ID_W-1:0] id);
		matcher_req_t r;
		r        = any_req();
		r.op     = OP_LOAD_SLOT;
		r.slot   = SLOT_W'(s);
		r.length = LEN_W'(len);
		r.id     = id;
		return r;
	endfunction

	function automatic matcher_req_t scan_req(logic [7:0] b);
		matcher_req_t r;
		r           = any_req();
		r.op        = OP_SCAN;
		r.scan_byte = b;
		return r;
	endfunction

	function automatic matcher_req_t nop_req();
		matcher_req_t r;
		r    = any_req();
		r.op = OP_NOP;
		return r;
	endfunction

	function automatic int written_prefix(int s);
		int n;
		n = 0;
		while (n < MAX_LEN && written[s][n])
			n++;
		return n;
	endfunction

	// Queue up the next run of scan bytes: mostly a walk through an enabled
	// slot's pattern with now and then a corrupted byte, else plain noise.
	function automatic void plan_scans();
		int         s;
		int         tries;
		logic [8:0] e;
		logic [7:0] b;
		s = -1;
		if ($urandom_range(0, 3) != 0) begin
			for (tries = 0; tries < 8 && s < 0; tries++) begin
				s = $urandom_range(0, SLOTS - 1);
				if (gen_len[s] == 0)
					s = -1;
			end
		end
		if (s < 0) begin
			repeat ($urandom_range(1, 6))
				scan_plan.push_back(pick_pattern_byte());
		end else begin
			for (int i = 0; i < gen_len[s]; i++) begin
				e = gen_elem[s][i];
				b = e[8] ? DIGIT_LO + 8'($urandom_range(0, 9)) : e[7:0];
				if ($urandom_range(0, 11) == 0)
					b = pick_pattern_byte();
				scan_plan.push_back(b);
			end
		end
	endfunction

	function automatic matcher_req_t next_random_req();
		matcher_req_t r;
		int           k;
		int           p;
		k = $urandom_range(0, 99);
		if (k < 9) begin
			// half the time grow the written prefix of the slot
			r = elem_req($urandom_range(0, SLOTS - 1), 0, pick_pattern_byte(),
				$urandom_range(0, 3) == 0);
			p = written_prefix(r.slot);
			if (p < MAX_LEN && $urandom_range(0, 1) != 0)
				r.position = POS_W'(p);
		end else if (k < 14) begin
			r = slot_req($urandom_range(0, SLOTS - 1), 0, ID_W'($urandom_range(0, 65535)));
			p = written_prefix(r.slot);
			r.length = LEN_W'((p == MAX_LEN) ? $urandom_range(0, 31) : $urandom_range(0, p));
		end else if (k < 17) begin
			r = nop_req();
		end else begin
			if (scan_plan.size() == 0)
				plan_scans();
			r = scan_req(scan_plan.pop_front());
		end
		return r;
	endfunction

	// Present one transaction and hold it until the block takes it. Called at
	// a clock edge; returns at the edge where the transaction was accepted.
	task automatic send_item(input matcher_req_t r);
		in_valid         <= 1'b1;
		operation        <= r.op;
		slot             <= r.slot;
		position         <= r.position;
		element_byte     <= r.elem_byte;
		element_is_digit <= r.elem_digit;
		pattern_length   <= r.length;
		pattern_id       <= r.id;
		byte_in          <= r.scan_byte;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		case (r.op)
			OP_LOAD_ELEM: begin
				written[r.slot][r.position]  = 1'b1;
				gen_elem[r.slot][r.position] = {r.elem_digit, r.elem_byte};
			end
			OP_LOAD_SLOT: begin
				gen_len[r.slot] = (r.length > LEN_MAX) ? MAX_LEN : r.length;
			end
			default: ;
		endcase
	endtask

	// Let the block run dry: no new transaction until every result is back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_matches.size() != 0)
			@(posedge clk);
	endtask

	task automatic fill_slot(input int s, input int len);
		for (int p = 0; p < MAX_LEN; p++)
			send_item(elem_req(s, p, pick_pattern_byte(), $urandom_range(0, 4) == 0));
		send_item(slot_req(s, len, ID_W'($urandom_range(0, 65535))));
	endtask

	initial begin
		int fill_len [4];
		int burst_left;
		int gap;
		int n;

		foreach (gen_len[i])
			gen_len[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: disabled table, unused op, a 3-element pattern ending in a
		// digit class, digit class against '[', no recheck after a miss, two
		// slots completing together, id 0 match, and a length reload.
		send_item(scan_req(8'h00));
		send_item(nop_req());
		send_item(elem_req(0, 0, "a", 1'b0));
		send_item(elem_req(0, 1, "b", 1'b0));
		send_item(elem_req(0, 2, "[", 1'b1));
		send_item(slot_req(0, 3, 16'hFFFF));
		send_item(scan_req("a"));
		send_item(scan_req("b"));
		send_item(scan_req("["));
		send_item(scan_req("a"));
		send_item(scan_req("b"));
		send_item(scan_req("9"));
		send_item(scan_req("a"));
		send_item(scan_req("a"));
		send_item(scan_req("b"));
		send_item(scan_req("0"));
		send_item(elem_req(7, 0, 8'hFF, 1'b0));
		send_item(slot_req(7, 1, 16'h0000));
		send_item(elem_req(1, MAX_LEN - 1, 8'hFF, 1'b1));
		send_item(elem_req(2, 0, "/", 1'b1));
		send_item(slot_req(2, 1, 16'h0002));
		send_item(scan_req("a"));
		send_item(scan_req("b"));
		send_item(scan_req("5"));
		send_item(scan_req(8'hFF));
		send_item(scan_req("a"));
		send_item(slot_req(0, 3, 16'h1234));
		send_item(scan_req("b"));
		send_item(scan_req("0"));

		// Random phases. Each starts from an empty pipeline, fully loads one
		// slot (covering oversize and exact-maximum lengths), then runs mixed
		// traffic in bursts separated by random gaps.
		fill_len[0] = 31;
		fill_len[1] = MAX_LEN;
		fill_len[2] = $urandom_range(MAX_LEN + 1, 30);
		fill_len[3] = $urandom_range(1, MAX_LEN);
		burst_left  = 0;
		for (int ph = 0; ph < 4; ph++) begin
			drain_results();
			fill_slot((ph * 3) % SLOTS, fill_len[ph]);
			scan_plan.delete();
			for (n = 0; n < 145; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					if (gap != 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				burst_left--;
				send_item(next_random_req());
			end
		end

		in_valid <= 1'b0;
		for (n = 0; n < 20000 && sb.expected_matches.size() != 0; n++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.expected_matches.size() != 0) begin
			$error("%0d results never arrived", sb.expected_matches.size());
			sb.error_count++;
		end

		$display("Covered %0d scans, %0d table loads and %0d unused-op transactions.",
			sb.scan_count, sb.load_count, sb.nop_count);
		$display("%0d scans reported a match; slots seen matching: %b",
			sb.hit_count, sb.slot_hit_mask);
		if (sb.error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/mpsm_pkg.sv
sv/mpsm_cell.sv
sv/multi_pattern_stream_matcher_top.sv
sv/mpsm_checker.sv
verif/multi_pattern_stream_matcher_top_tb.sv
